// ===== src/lzss_pkg.sv =====
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int ADDR_W = $clog2(WINDOW_SIZE);

  localparam logic [1:0] HEADER_LAST = 2'd3;
  localparam logic [3:0] FLAG_COUNT = 4'd8;
  localparam logic [4:0] LEN_BIAS = 5'd3;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_CONTROL = 7'b0000010,
    PH_LITERAL = 7'b0000100,
    PH_REF_HI  = 7'b0001000,
    PH_REF_LO  = 7'b0010000,
    PH_COPY    = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

endpackage

`default_nettype wire

// ===== src/lzss_in_if.sv =====
`default_nettype none

interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;

  modport source(output valid, output in_byte, output first_byte, input ready);
  modport sink(input valid, input in_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// ===== src/lzss_out_if.sv =====
`default_nettype none

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;
  logic       bad_reference;

  modport source(output valid, output out_byte, output last_of_run, output stream_done,
                 output bad_reference, input ready);
  modport sink(input valid, input out_byte, input last_of_run, input stream_done,
               input bad_reference, output ready);
endinterface

`default_nettype wire

// ===== src/lzss_ram.sv =====
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lzss_byte_decompressor.sv =====
// Channel     Dir  Payload                                              Handshake
// compressed  in   in_byte[7:0], first_byte                             valid/ready
// expanded    out  out_byte[7:0], last_of_run, stream_done, bad_reference  valid/ready
//
// A header, control or reference high byte gives no result.
// A literal gives one output byte; a back-reference gives its length (3 to 18) in bytes,
// one output byte per cycle unless the output stalls, read from the 4096-byte history RAM.
// Reset is synchronous; the history RAM is not cleared, only written bytes are read.
// A stalled output register stalls the copy sequencer and holds input ready low.
`default_nettype none

module lzss_byte_decompressor
  import lzss_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  lzss_in_if.sink   compressed,
  lzss_out_if.source expanded
);

  phase_t             phase, phase_next;
  logic [1:0]         header_count, header_count_next;
  logic [7:0]         flag_bits, flag_bits_next;
  logic [3:0]         flags_left, flags_left_next;
  logic [7:0]         ref_high_byte, ref_high_byte_next;
  logic [31:0]        target_length, target_length_next;
  logic [31:0]        produced_count, produced_count_next;
  logic [4:0]         copy_left, copy_left_next;
  logic [ADDR_W-1:0]  copy_src, copy_src_next;
  logic               reached, reached_next;
  logic               fwd_hit;
  logic [7:0]         fwd_data;

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last, out_done, out_bad;

  phase_t             base_phase;
  logic [1:0]         base_hc;
  logic [7:0]         base_fb;
  logic [3:0]         base_fl;
  logic [7:0]         base_ref;
  logic [31:0]        base_tl;
  logic [31:0]        base_pc;

  logic               in_fire, out_free;
  logic               emit, emit_last, emit_done, emit_bad;
  logic [7:0]         emit_byte;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [7:0]         wr_data, ram_q, copy_byte;
  logic [15:0]        word;
  logic [12:0]        ref_dist;
  logic [31:0]        pc_inc;
  logic [31:0]        tl_shift;
  logic               hit;
  logic [7:0]         fb_shift;
  logic [3:0]         fl_dec;

  function automatic phase_t next_phase(input logic done, input logic [3:0] fl,
                                        input logic [7:0] fb);
    phase_t p;
    if (done) begin
      p = PH_DONE;
    end else if (fl == 4'd0) begin
      p = PH_CONTROL;
    end else if (fb[0]) begin
      p = PH_REF_HI;
    end else begin
      p = PH_LITERAL;
    end
    return p;
  endfunction

  assign out_free = !out_valid || expanded.ready;
  assign compressed.ready = (phase != PH_COPY) && out_free;
  assign in_fire = compressed.valid && compressed.ready;

  always_comb begin
    if (in_fire && compressed.first_byte) begin
      base_phase = PH_HEADER;
      base_hc    = 2'd0;
      base_fb    = 8'd0;
      base_fl    = 4'd0;
      base_ref   = 8'd0;
      base_tl    = 32'd0;
      base_pc    = 32'd0;
    end else begin
      base_phase = phase;
      base_hc    = header_count;
      base_fb    = flag_bits;
      base_fl    = flags_left;
      base_ref   = ref_high_byte;
      base_tl    = target_length;
      base_pc    = produced_count;
    end
  end

  assign word      = {base_ref, compressed.in_byte};
  assign ref_dist  = {1'b0, word[11:0]} + 13'd1;
  assign pc_inc    = base_pc + 32'd1;
  assign hit       = (pc_inc == base_tl);
  assign tl_shift  = {base_tl[23:0], compressed.in_byte};
  assign fb_shift  = {1'b0, base_fb[7:1]};
  assign fl_dec    = base_fl - 4'd1;
  assign copy_byte = fwd_hit ? fwd_data : ram_q;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    flag_bits_next      = flag_bits;
    flags_left_next     = flags_left;
    ref_high_byte_next  = ref_high_byte;
    target_length_next  = target_length;
    produced_count_next = produced_count;
    copy_left_next      = copy_left;
    copy_src_next       = copy_src;
    reached_next        = reached;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    emit_done = 1'b0;
    emit_bad  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = base_pc[ADDR_W-1:0];
    wr_data   = 8'd0;
    rd_en     = 1'b0;
    rd_addr   = copy_src;

    if (in_fire) begin
      phase_next          = base_phase;
      header_count_next   = base_hc;
      flag_bits_next      = base_fb;
      flags_left_next     = base_fl;
      ref_high_byte_next  = base_ref;
      target_length_next  = base_tl;
      produced_count_next = base_pc;
      case (base_phase)
        PH_HEADER: begin
          target_length_next = tl_shift;
          header_count_next  = base_hc + 2'd1;
          if (base_hc == HEADER_LAST) begin
            phase_next = (tl_shift == 32'd0) ? PH_DONE : PH_CONTROL;
          end
        end
        PH_CONTROL: begin
          flag_bits_next  = compressed.in_byte;
          flags_left_next = FLAG_COUNT;
          phase_next = compressed.in_byte[0] ? PH_REF_HI : PH_LITERAL;
        end
        PH_LITERAL: begin
          emit      = 1'b1;
          emit_byte = compressed.in_byte;
          emit_last = 1'b1;
          emit_done = hit;
          wr_en     = 1'b1;
          wr_data   = compressed.in_byte;
          produced_count_next = pc_inc;
          flag_bits_next  = fb_shift;
          flags_left_next = fl_dec;
          phase_next = next_phase(hit, fl_dec, fb_shift);
        end
        PH_REF_HI: begin
          ref_high_byte_next = compressed.in_byte;
          phase_next = PH_REF_LO;
        end
        PH_REF_LO: begin
          if ({19'd0, ref_dist} > base_pc) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_bad  = 1'b1;
            phase_next = PH_DONE;
          end else begin
            copy_left_next = {1'b0, word[15:12]} + LEN_BIAS;
            copy_src_next  = base_pc[ADDR_W-1:0] - word[ADDR_W-1:0] - 12'd1;
            rd_en          = 1'b1;
            rd_addr        = copy_src_next;
            reached_next   = 1'b0;
            phase_next     = PH_COPY;
          end
        end
        default: begin
        end
      endcase
    end else if (phase == PH_COPY && out_free) begin
      emit      = 1'b1;
      emit_byte = copy_byte;
      emit_last = (copy_left == 5'd1);
      emit_done = reached || hit;
      wr_en     = 1'b1;
      wr_data   = copy_byte;
      produced_count_next = pc_inc;
      reached_next   = reached || hit;
      copy_left_next = copy_left - 5'd1;
      if (copy_left != 5'd1) begin
        copy_src_next = copy_src + 12'd1;
        rd_en         = 1'b1;
        rd_addr       = copy_src_next;
      end else begin
        flag_bits_next  = fb_shift;
        flags_left_next = fl_dec;
        phase_next = next_phase(reached || hit, fl_dec, fb_shift);
      end
    end
  end

  lzss_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_history (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // A run with distance one reads the entry written in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 2'd0;
      flag_bits      <= 8'd0;
      flags_left     <= 4'd0;
      ref_high_byte  <= 8'd0;
      target_length  <= 32'd0;
      produced_count <= 32'd0;
      copy_left      <= 5'd0;
      copy_src       <= '0;
      reached        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      flag_bits      <= flag_bits_next;
      flags_left     <= flags_left_next;
      ref_high_byte  <= ref_high_byte_next;
      target_length  <= target_length_next;
      produced_count <= produced_count_next;
      copy_left      <= copy_left_next;
      copy_src       <= copy_src_next;
      reached        <= reached_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (expanded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
      out_done <= emit_done;
      out_bad  <= emit_bad;
    end
  end

  assign expanded.valid         = out_valid;
  assign expanded.out_byte      = out_byte;
  assign expanded.last_of_run   = out_last;
  assign expanded.stream_done   = out_done;
  assign expanded.bad_reference = out_bad;

endmodule

`default_nettype wire

// ===== src/lzss_checker.sv =====
`default_nettype none

module lzss_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run,
  input wire logic       stream_done,
  input wire logic       bad_reference
);

  // A result that waits keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run)
      && $stable(stream_done) && $stable(bad_reference))
    else $error("output request changed while stalled");

  // An error result is a single, final, zero byte.
  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_reference |-> last_of_run && !stream_done && (out_byte == 8'd0))
    else $error("malformed error result");

  // No new request is taken while a result is stuck in the output register.
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted with a stalled output");

  // After an error result is taken, the stream gives nothing more in the next cycle.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && bad_reference |=> !out_valid)
    else $error("result after an error result");

  // A request is never taken while a result waits in the output register.
  a_in_ready_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("request accepted while output stalled");

endmodule

bind lzss_byte_decompressor lzss_checker u_lzss_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(compressed.valid),
  .in_ready(compressed.ready),
  .out_valid(expanded.valid),
  .out_ready(expanded.ready),
  .out_byte(expanded.out_byte),
  .last_of_run(expanded.last_of_run),
  .stream_done(expanded.stream_done),
  .bad_reference(expanded.bad_reference)
);

`default_nettype wire
